>>> rtl/gtpc_pkg.sv
// Shared constants, types and tables for the gimbal tilt/pitch compensation block.
// No dependencies; every module of the block imports this package, the interfaces do not.
package gtpc_pkg;

  // Encoder counts per turn; must be a power of two.
  localparam int ENCODER_COUNTS = 8192;
  localparam int ENC_BITS       = $clog2(ENCODER_COUNTS);
  localparam int PHASE_W        = 32;
  localparam int ENC_SHIFT      = PHASE_W - ENC_BITS;

  // One turn in hundredths of a degree.
  localparam int TURN_CDEG = 36000;
  localparam int WRED_W    = 16;

  // floor(w * 2^32 / 36000) = w * PH_STEP + floor(w * PH_REM / 36000)
  localparam longint unsigned PH_STEP   = (64'd1 << PHASE_W) / TURN_CDEG;
  localparam longint unsigned PH_REM    = (64'd1 << PHASE_W) - PH_STEP * TURN_CDEG;
  localparam int              PH_K      = 45;
  localparam longint unsigned PH_RECIP  = ((64'd1 << PH_K) + TURN_CDEG - 1) / TURN_CDEG;
  localparam int              REMP_W    = 30;
  localparam int              RECIP_W   = 30;
  localparam int              QF_W      = 15;

  // Pipeline depth: input register through result register.
  localparam int NSTG = 12;

  // CORDIC
  localparam int CORDIC_STAGES = 16;
  localparam int CORDIC_REGS   = 4;
  localparam int STEPS_PER_REG = CORDIC_STAGES / CORDIC_REGS;
  localparam int XY_W          = 19;
  localparam int Z_W           = 32;
  localparam int CORDIC_GAIN   = 39797;

  localparam logic signed [Z_W-1:0] ATAN_TURN [CORDIC_STAGES] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861
  };

  // Quadrant codes from the top two phase bits.
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // Output scaling: (pitch*cos + roll*sin) * 8192 / (18000 * 65536) = sum / OUT_DIV
  localparam longint unsigned OUT_DIV   = (64'd18000 * 64'd65536) / 64'd8192;
  localparam int              MAG_W     = 33;
  localparam int              OUT_K     = MAG_W;
  localparam longint unsigned OUT_RECIP = (64'd1 << OUT_K) / OUT_DIV;
  localparam int              QE_W      = 16;

  // Configuration port
  localparam int         CFG_IDX_W         = 1;
  localparam int         CFG_DATA_W        = 16;
  localparam logic [0:0] CFG_MOUNT_OFFSET  = 1'd0;
  localparam logic [0:0] CFG_TILT_DEADBAND = 1'd1;

  typedef struct packed {
    logic signed [14:0] pitch;
    logic signed [15:0] roll;
    logic signed [15:0] yaw;
    logic [12:0]        enc;
  } sample_t;

  typedef struct packed {
    logic signed [14:0] pitch;
    logic signed [15:0] roll;
  } tilt_t;

endpackage

>>> rtl/gtpc_in_if.sv
// Sample channel: chassis attitude and gimbal encoder beat with valid/ready.
// No dependencies.
interface gtpc_in_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] chassis_pitch;
  logic signed [15:0] chassis_roll;
  logic signed [15:0] chassis_yaw;
  logic [12:0]        gimbal_encoder;

  modport source (output valid, output chassis_pitch, output chassis_roll,
                  output chassis_yaw, output gimbal_encoder, input ready);
  modport sink   (input valid, input chassis_pitch, input chassis_roll,
                  input chassis_yaw, input gimbal_encoder, output ready);
endinterface

>>> rtl/gtpc_out_if.sv
// Result channel: one pitch correction beat with valid/ready.
// No dependencies.
interface gtpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pitch_corr;

  modport source (output valid, output pitch_corr, input ready);
  modport sink   (input valid, input pitch_corr, output ready);
endinterface

>>> rtl/gimbal_tilt_pitch_compensation.sv
// Gimbal pitch compensation from chassis tilt: top level with config registers and
// pipeline flow control. Depends on gtpc_pkg, gtpc_in_if, gtpc_out_if, gtpc_phase,
// gtpc_cordic and gtpc_scale.
//
// Usage:
//   sample carries chassis pitch, roll, yaw and the gimbal encoder count; a beat is
//   taken when valid and ready are both high. result carries one pitch_corr
//   beat per sample, in order. The config port writes mount_offset (index 0) and
//   tilt_deadband (index 1) on any edge with cfg_we high; write them while idle.
//   Throughput is one sample per cycle while result is not held by the receiver. A
//   sample accepted at one edge passes through the input register, four stages for
//   the phase (deadband and yaw fold, two constant multiplies, reciprocal multiply,
//   phase add), four CORDIC stages of four iterations each, then products, quotient
//   estimate and the correction/saturation stage that drives the result register.
//   Each stage holds its beat only when the stage after it is full and stalled, so
//   while result is held by the receiver sample stays ready until every bubble in
//   the pipeline is filled. Reset empties the pipeline and loads mount_offset = 3800
//   and tilt_deadband = 100; no clearing pass is needed.
module gimbal_tilt_pitch_compensation (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [gtpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gtpc_pkg::CFG_DATA_W-1:0]    cfg_data,
  gtpc_in_if.sink                            sample,
  gtpc_out_if.source                         result
);
  import gtpc_pkg::*;

  logic signed [15:0] mount_offset;
  logic [13:0]        tilt_deadband;

  logic [NSTG-1:0]    vld;
  logic [NSTG-1:0]    en;
  sample_t            smp;

  tilt_t                  tilt_p;
  logic [31:0]            phase_p;
  tilt_t                  tilt_c;
  logic signed [XY_W-1:0] x_c;
  logic signed [XY_W-1:0] y_c;
  logic [1:0]             quad_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      mount_offset  <= 16'sd3800;
      tilt_deadband <= 14'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MOUNT_OFFSET:  mount_offset  <= signed'(cfg_data);
        CFG_TILT_DEADBAND: tilt_deadband <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or its beat moves on this cycle.
  always_comb begin
    en[NSTG-1] = !vld[NSTG-1] || result.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (en[k]) begin
          vld[k] <= (k == 0) ? sample.valid : vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      smp.pitch <= sample.chassis_pitch;
      smp.roll  <= sample.chassis_roll;
      smp.yaw   <= sample.chassis_yaw;
      smp.enc   <= sample.gimbal_encoder;
    end
  end

  assign sample.ready = en[0];
  assign result.valid = vld[NSTG-1];

  gtpc_phase u_phase (
    .clk           (clk),
    .en            (en[4:1]),
    .smp           (smp),
    .mount_offset  (mount_offset),
    .tilt_deadband (tilt_deadband),
    .tilt_out      (tilt_p),
    .phase_out     (phase_p)
  );

  gtpc_cordic u_cordic (
    .clk      (clk),
    .en       (en[8:5]),
    .tilt_in  (tilt_p),
    .phase_in (phase_p),
    .tilt_out (tilt_c),
    .x_out    (x_c),
    .y_out    (y_c),
    .quad_out (quad_c)
  );

  gtpc_scale u_scale (
    .clk        (clk),
    .en         (en[11:9]),
    .tilt_in    (tilt_c),
    .x_in       (x_c),
    .y_in       (y_c),
    .quad_in    (quad_c),
    .pitch_corr (result.pitch_corr)
  );

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid right after reset");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> vld[0])
    else $error("accepted sample missing from input stage");

  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    ((&vld) && !result.ready) |-> !sample.ready)
    else $error("sample ready while pipeline full and stalled");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (vld[NSTG-2] && vld[NSTG-1] && !result.ready) |=> vld[NSTG-2])
    else $error("beat lost behind stalled result");
`endif

endmodule

>>> rtl/gtpc_phase.sv
// Deadband and relative-yaw phase: four pipeline stages ending in a 32-bit turn phase.
// Depends on gtpc_pkg.
module gtpc_phase (
  input  logic                    clk,
  input  logic [3:0]              en,
  input  gtpc_pkg::sample_t       smp,
  input  logic signed [15:0]      mount_offset,
  input  logic [13:0]             tilt_deadband,
  output gtpc_pkg::tilt_t         tilt_out,
  output logic [31:0]             phase_out
);
  import gtpc_pkg::*;

  // stage 1
  logic signed [16:0] wsum;
  logic [17:0]        vpos;
  logic [WRED_W-1:0]  wred;
  logic signed [16:0] dbs;
  logic signed [16:0] p17;
  logic signed [16:0] r17;
  tilt_t              tilt1_next;
  tilt_t              tilt1;
  logic [12:0]        enc1;
  logic [WRED_W-1:0]  wred1;

  // stage 2
  logic [47:0]        base_full;
  logic [47:0]        remp_full;
  tilt_t              tilt2;
  logic [12:0]        enc2;
  logic [PHASE_W-1:0] base2;
  logic [REMP_W-1:0]  remp2;

  // stage 3
  logic [REMP_W+RECIP_W-1:0] qprod;
  tilt_t                     tilt3;
  logic [12:0]               enc3;
  logic [PHASE_W-1:0]        base3;
  logic [QF_W-1:0]           qf3;

  // stage 4
  logic [PHASE_W-1:0] phase_next;
  tilt_t              tilt4;
  logic [PHASE_W-1:0] phase4;

  always_comb begin
    wsum = 17'(smp.yaw) + 17'(mount_offset);
    // -(yaw + offset) shifted positive by two turns, then folded into one turn
    vpos = 18'(2 * TURN_CDEG) - 18'(wsum);
    if (vpos >= 18'(3 * TURN_CDEG)) begin
      wred = WRED_W'(vpos - 18'(3 * TURN_CDEG));
    end else if (vpos >= 18'(2 * TURN_CDEG)) begin
      wred = WRED_W'(vpos - 18'(2 * TURN_CDEG));
    end else if (vpos >= 18'(TURN_CDEG)) begin
      wred = WRED_W'(vpos - 18'(TURN_CDEG));
    end else begin
      wred = WRED_W'(vpos);
    end

    dbs = signed'(17'(tilt_deadband));
    p17 = 17'(smp.pitch);
    r17 = 17'(smp.roll);
    tilt1_next.pitch = ((p17 > -dbs) && (p17 < dbs)) ? '0 : smp.pitch;
    tilt1_next.roll  = ((r17 > -dbs) && (r17 < dbs)) ? '0 : smp.roll;
  end

  always_comb begin
    base_full  = 48'(wred1) * 48'(PH_STEP);
    remp_full  = 48'(wred1) * 48'(PH_REM);
    qprod      = (REMP_W+RECIP_W)'(remp2) * (REMP_W+RECIP_W)'(PH_RECIP);
    phase_next = (PHASE_W'(enc3) << ENC_SHIFT) + base3 + PHASE_W'(qf3);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      tilt1 <= tilt1_next;
      enc1  <= smp.enc;
      wred1 <= wred;
    end
    if (en[1]) begin
      tilt2 <= tilt1;
      enc2  <= enc1;
      base2 <= base_full[PHASE_W-1:0];
      remp2 <= remp_full[REMP_W-1:0];
    end
    if (en[2]) begin
      tilt3 <= tilt2;
      enc3  <= enc2;
      base3 <= base2;
      qf3   <= QF_W'(qprod >> PH_K);
    end
    if (en[3]) begin
      tilt4  <= tilt3;
      phase4 <= phase_next;
    end
  end

  assign tilt_out  = tilt4;
  assign phase_out = phase4;

endmodule

>>> rtl/gtpc_cordic.sv
// Rotation-mode CORDIC for cosine and sine in Q16, four steps per pipeline register.
// Depends on gtpc_pkg.
module gtpc_cordic (
  input  logic                          clk,
  input  logic [gtpc_pkg::CORDIC_REGS-1:0] en,
  input  gtpc_pkg::tilt_t               tilt_in,
  input  logic [31:0]                   phase_in,
  output gtpc_pkg::tilt_t               tilt_out,
  output logic signed [gtpc_pkg::XY_W-1:0] x_out,
  output logic signed [gtpc_pkg::XY_W-1:0] y_out,
  output logic [1:0]                    quad_out
);
  import gtpc_pkg::*;

  logic signed [XY_W-1:0] x_r    [CORDIC_REGS];
  logic signed [XY_W-1:0] y_r    [CORDIC_REGS];
  logic signed [Z_W-1:0]  z_r    [CORDIC_REGS];
  logic [1:0]             quad_r [CORDIC_REGS];
  tilt_t                  tilt_r [CORDIC_REGS];

  logic signed [XY_W-1:0] x_n [CORDIC_REGS];
  logic signed [XY_W-1:0] y_n [CORDIC_REGS];
  logic signed [Z_W-1:0]  z_n [CORDIC_REGS];

  always_comb begin
    logic signed [XY_W-1:0] xc;
    logic signed [XY_W-1:0] yc;
    logic signed [Z_W-1:0]  zc;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    for (int g = 0; g < CORDIC_REGS; g++) begin
      if (g == 0) begin
        xc = XY_W'(CORDIC_GAIN);
        yc = '0;
        zc = signed'({2'b00, phase_in[29:0]});
      end else begin
        xc = x_r[g-1];
        yc = y_r[g-1];
        zc = z_r[g-1];
      end
      for (int j = 0; j < STEPS_PER_REG; j++) begin
        dx = yc >>> (g * STEPS_PER_REG + j);
        dy = xc >>> (g * STEPS_PER_REG + j);
        if (!zc[Z_W-1]) begin
          xc = xc - dx;
          yc = yc + dy;
          zc = zc - ATAN_TURN[4'(g * STEPS_PER_REG + j)];
        end else begin
          xc = xc + dx;
          yc = yc - dy;
          zc = zc + ATAN_TURN[4'(g * STEPS_PER_REG + j)];
        end
      end
      x_n[g] = xc;
      y_n[g] = yc;
      z_n[g] = zc;
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < CORDIC_REGS; g++) begin
      if (en[g]) begin
        x_r[g]    <= x_n[g];
        y_r[g]    <= y_n[g];
        z_r[g]    <= z_n[g];
        quad_r[g] <= (g == 0) ? phase_in[31:30] : quad_r[g-1];
        tilt_r[g] <= (g == 0) ? tilt_in : tilt_r[g-1];
      end
    end
  end

  assign x_out    = x_r[CORDIC_REGS-1];
  assign y_out    = y_r[CORDIC_REGS-1];
  assign quad_out = quad_r[CORDIC_REGS-1];
  assign tilt_out = tilt_r[CORDIC_REGS-1];

endmodule

>>> rtl/gtpc_scale.sv
// Quadrant mapping, tilt products and scaling to pi = 8192 with truncation and saturation.
// Depends on gtpc_pkg.
module gtpc_scale (
  input  logic                             clk,
  input  logic [2:0]                       en,
  input  gtpc_pkg::tilt_t                  tilt_in,
  input  logic signed [gtpc_pkg::XY_W-1:0] x_in,
  input  logic signed [gtpc_pkg::XY_W-1:0] y_in,
  input  logic [1:0]                       quad_in,
  output logic signed [15:0]               pitch_corr
);
  import gtpc_pkg::*;

  logic signed [XY_W-1:0] cosv;
  logic signed [XY_W-1:0] sinv;
  logic signed [33:0]     pc_next;
  logic signed [34:0]     rs_next;
  logic signed [33:0]     pc;
  logic signed [34:0]     rs;

  logic signed [35:0]     sum;
  logic [35:0]            mag_full;
  logic [MAG_W-1:0]       mag_next;
  logic [MAG_W+15:0]      qprod;
  logic [QE_W-1:0]        qe;
  logic [MAG_W-1:0]       mag;
  logic                   neg;

  logic [34:0]            back;
  logic [34:0]            rem;
  logic [16:0]            qc;
  logic signed [15:0]     res_next;
  logic signed [15:0]     res;

  always_comb begin
    case (quad_in)
      QUAD_0: begin
        cosv = x_in;
        sinv = y_in;
      end
      QUAD_1: begin
        cosv = -y_in;
        sinv = x_in;
      end
      QUAD_2: begin
        cosv = -x_in;
        sinv = -y_in;
      end
      QUAD_3: begin
        cosv = y_in;
        sinv = -x_in;
      end
      default: begin
        cosv = '0;
        sinv = '0;
      end
    endcase
    pc_next = 34'(tilt_in.pitch) * 34'(cosv);
    rs_next = 35'(tilt_in.roll) * 35'(sinv);
  end

  always_comb begin
    sum      = 36'(pc) + 36'(rs);
    mag_full = sum[35] ? 36'(-sum) : 36'(sum);
    mag_next = mag_full[MAG_W-1:0];
    qprod    = (MAG_W+16)'(mag_next) * (MAG_W+16)'(OUT_RECIP);
  end

  // Quotient estimate is exact or one short; fix it with the remainder.
  always_comb begin
    back = 35'(qe) * 35'(OUT_DIV);
    rem  = 35'(mag) - back;
    qc   = 17'(qe) + ((rem >= 35'(OUT_DIV)) ? 17'd1 : 17'd0);
    if (neg) begin
      res_next = (qc >= 17'd32768) ? -16'sd32768 : 16'(-signed'(qc));
    end else begin
      res_next = (qc > 17'd32767) ? 16'sd32767 : 16'(qc);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pc <= pc_next;
      rs <= rs_next;
    end
    if (en[1]) begin
      qe  <= QE_W'(qprod >> OUT_K);
      mag <= mag_next;
      neg <= sum[35];
    end
    if (en[2]) begin
      res <= res_next;
    end
  end

  assign pitch_corr = res;

endmodule
